// ===== design/ilf_pkg.sv =====
package ilf_pkg;

    localparam int COLOR_W = 32;
    localparam int TIME_W = 32;
    localparam int INTERVAL_W = 16;
    localparam int PIXEL_W = 8;
    localparam int LEVEL_W = 8;
    localparam int MODE_W = 3;

    typedef enum logic [2:0] {
        FUNC_SET_LEVEL  = 3'd0,
        FUNC_SET_CUSTOM = 3'd1,
        FUNC_CLEAR_ALL  = 3'd2,
        FUNC_SET_WORK   = 3'd3,
        FUNC_UPDATE     = 3'd4
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 3'd0,
        MODE_NORMAL   = 3'd1,
        MODE_WARNING  = 3'd2,
        MODE_CRITICAL = 3'd3,
        MODE_INFO     = 3'd4
    } mode_t;

    // One icon entry as it sits in the icon memory.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               flash;
        logic [LEVEL_W-1:0] level;
        logic [COLOR_W-1:0] custom;
        logic               use_custom;
        logic [TIME_W-1:0]  last_toggle;
        logic               phase;
    } icon_entry_t;

    localparam int ENTRY_W = $bits(icon_entry_t);

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
    localparam logic [PIXEL_W-1:0] WORK_START_RESET = 8'd48;
    localparam logic [PIXEL_W-1:0] WORK_END_RESET = 8'd70;
    localparam logic [COLOR_W-1:0] WORK_COLOR_RESET = 32'h00FF_FFFF;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;

    localparam icon_entry_t ICON_RESET = '{
        mode:        MODE_OFF,
        flash:       1'b0,
        level:       LEVEL_FULL,
        custom:      '0,
        use_custom:  1'b0,
        last_toggle: '0,
        phase:       1'b0
    };

    function automatic logic [COLOR_W-1:0] palette(input logic [MODE_W-1:0] mode);
        logic [COLOR_W-1:0] c;
        unique case (mode)
            MODE_NORMAL:   c = 32'h0000_FF00;
            MODE_WARNING:  c = 32'h00FF_A500;
            MODE_CRITICAL: c = 32'h00FF_0000;
            MODE_INFO:     c = 32'h0000_00FF;
            default:       c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ilf_ram.sv =====
module ilf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ilf_scale.sv =====
module ilf_scale
    import ilf_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [COLOR_W-1:0] color,
    input  logic [LEVEL_W-1:0] level,
    output logic [COLOR_W-1:0] scaled
);

    // Products are registered; the divide by 255 follows as an add and shift,
    // which is exact for any product of two 8-bit values.
    logic [15:0] prod_reg [4];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= color[8*k +: 8] * level;
            end
        end
    end

    always_comb
    begin
        logic [16:0] sum;
        scaled = '0;
        for (int k = 0; k < 4; k++)
        begin
            sum = 17'(prod_reg[k]) + 17'd1 + 17'(prod_reg[k][15:8]);
            scaled[8*k +: 8] = sum[15:8];
        end
    end

endmodule

// ===== design/indicator_led_flasher.sv =====
// Channel   Direction  Handshake               Contents
// s_*       in         s_tvalid / s_tready     commands and update items, func in s_tuser
// m_*       out        m_tvalid / m_tready     pixel ranges with colour, show in m_tuser
// cfg_*     in         cfg_valid / cfg_ready   flash interval in milliseconds
//
// A set-icon command keeps the input busy after its transfer through a read and a
// write-back of its icon, and of the partner icon too when it is a linked icon.
// Clear-all and set-work-light commands complete without leaving the idle state,
// and configuration writes are always accepted. An update walks every icon, each
// a read, an evaluate-and-write-back and an output step through the single icon
// memory, and then the work light, an evaluate and an output step.
// Reset clears the per-icon valid bits at once, so no clearing pass is needed.
// A stall on m_tready holds the walk at its output step.
module indicator_led_flasher
    import ilf_pkg::*;
#(
    parameter int NUM_ICONS = 10,
    parameter int ICON_PIXEL_BASE = 0,
    parameter int LINKED_LEFT = 4,
    parameter int LINKED_RIGHT = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // icon[3:0], warning_state[6:4], flash_on[7], level[15:8], color_word[47:16],
    // enable[48], range_start[56:49], range_end[64:57], time_ms[96:65], zeros above
    input  logic [103:0] s_tdata,
    // func[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_first[7:0], pixel_last[15:8], pixel_color[47:16]
    output logic [47:0]  m_tdata,
    // show[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int IDX_W = (NUM_ICONS > 1) ? $clog2(NUM_ICONS) : 1;

    // The sequencer walks one entry at a time: a read, then the modify and
    // write-back. Accesses to the same entry never overlap, so the memory
    // needs no forwarding path.
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SET_RD   = 8'b0000_0010,
        ST_SET_WR   = 8'b0000_0100,
        ST_UPD_RD   = 8'b0000_1000,
        ST_UPD_EV   = 8'b0001_0000,
        ST_UPD_OUT  = 8'b0010_0000,
        ST_WORK_EV  = 8'b0100_0000,
        ST_WORK_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Input fields.
    logic [3:0]          in_icon;
    logic [MODE_W-1:0]   in_wstate;
    logic                in_flash;
    logic [LEVEL_W-1:0]  in_level;
    logic [COLOR_W-1:0]  in_color;
    logic                in_enable;
    logic [PIXEL_W-1:0]  in_start;
    logic [PIXEL_W-1:0]  in_end;
    logic [TIME_W-1:0]   in_time;
    func_t               in_func;

    assign in_icon   = s_tdata[3:0];
    assign in_wstate = s_tdata[6:4];
    assign in_flash  = s_tdata[7];
    assign in_level  = s_tdata[15:8];
    assign in_color  = s_tdata[47:16];
    assign in_enable = s_tdata[48];
    assign in_start  = s_tdata[56:49];
    assign in_end    = s_tdata[64:57];
    assign in_time   = s_tdata[96:65];
    assign in_func   = func_t'(s_tuser);

    logic in_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Command and walk registers.
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    partner_reg, partner_next;
    logic                partner_pend_reg, partner_pend_next;
    logic [MODE_W-1:0]   cmd_mode_reg, cmd_mode_next;
    logic                cmd_use_reg, cmd_use_next;
    logic                cmd_keep_reg, cmd_keep_next;
    logic [COLOR_W-1:0]  cmd_color_reg, cmd_color_next;
    logic                cmd_flash_reg, cmd_flash_next;
    logic [LEVEL_W-1:0]  cmd_level_reg, cmd_level_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic                toggled_reg, toggled_next;
    logic                rd_valid_reg, rd_valid_next;

    logic [NUM_ICONS-1:0] valid_reg, valid_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                 refresh_reg, refresh_next;

    // Work-light state.
    logic                 work_enable_reg, work_enable_next;
    logic [PIXEL_W-1:0]   work_start_reg, work_start_next;
    logic [PIXEL_W-1:0]   work_end_reg, work_end_next;
    logic [LEVEL_W-1:0]   work_level_reg, work_level_next;
    logic [COLOR_W-1:0]   work_color_reg, work_color_next;
    logic                 work_flash_reg, work_flash_next;
    logic [TIME_W-1:0]    work_toggle_reg, work_toggle_next;
    logic                 work_phase_reg, work_phase_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]   out_first_reg, out_first_next;
    logic [PIXEL_W-1:0]   out_last_px_reg, out_last_px_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic                 out_show_reg, out_show_next;
    logic                 out_end_reg, out_end_next;

    // Icon memory and scaler connections.
    logic                 mem_we;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [ENTRY_W-1:0]   mem_rdata;
    logic                 scale_load;
    logic [COLOR_W-1:0]   scale_color;
    logic [LEVEL_W-1:0]   scale_level;
    logic [COLOR_W-1:0]   scaled;

    ilf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ICONS)
    ) u_icon_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    ilf_scale u_scale (
        .clk    (clk),
        .load   (scale_load),
        .color  (scale_color),
        .level  (scale_level),
        .scaled (scaled)
    );

    assign mem_re = (state_reg == ST_SET_RD) || (state_reg == ST_UPD_RD);

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        icon_entry_t base;
        icon_entry_t ne;
        logic        icon_ok;
        logic        is_left;
        logic        is_right;
        logic        flashing;
        logic        tog;
        logic [TIME_W-1:0]  elapsed;
        logic [COLOR_W-1:0] c;

        state_next        = state_reg;
        addr_next         = addr_reg;
        partner_next      = partner_reg;
        partner_pend_next = partner_pend_reg;
        cmd_mode_next     = cmd_mode_reg;
        cmd_use_next      = cmd_use_reg;
        cmd_keep_next     = cmd_keep_reg;
        cmd_color_next    = cmd_color_reg;
        cmd_flash_next    = cmd_flash_reg;
        cmd_level_next    = cmd_level_reg;
        time_next         = time_reg;
        toggled_next      = toggled_reg;
        rd_valid_next     = rd_valid_reg;
        valid_next        = valid_reg;
        refresh_next      = refresh_reg;
        interval_next     = interval_reg;
        work_enable_next  = work_enable_reg;
        work_start_next   = work_start_reg;
        work_end_next     = work_end_reg;
        work_level_next   = work_level_reg;
        work_color_next   = work_color_reg;
        work_flash_next   = work_flash_reg;
        work_toggle_next  = work_toggle_reg;
        work_phase_next   = work_phase_reg;
        out_first_next    = out_first_reg;
        out_last_px_next  = out_last_px_reg;
        out_color_next    = out_color_reg;
        out_show_next     = out_show_reg;
        out_end_next      = out_end_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        mem_we            = 1'b0;
        scale_load        = 1'b0;
        scale_color       = '0;
        scale_level       = LEVEL_FULL;

        icon_ok  = {2'b00, in_icon} < 6'(NUM_ICONS);
        is_left  = {2'b00, in_icon} == 6'(LINKED_LEFT);
        is_right = {2'b00, in_icon} == 6'(LINKED_RIGHT);

        base = rd_valid_reg ? icon_entry_t'(mem_rdata) : ICON_RESET;
        ne   = base;
        flashing = base.flash && (base.mode != MODE_OFF);
        elapsed  = time_reg - base.last_toggle;
        tog      = 1'b0;
        c        = '0;
        mem_wdata = ENTRY_W'(ne);

        if (cfg_valid && (cfg_data != '0))
        begin
            interval_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    time_next      = in_time;
                    cmd_flash_next = in_flash;
                    cmd_level_next = in_level;
                    cmd_color_next = in_color;
                    unique case (in_func)
                        FUNC_SET_LEVEL, FUNC_SET_CUSTOM:
                        begin
                            if (icon_ok)
                            begin
                                addr_next     = IDX_W'(in_icon);
                                cmd_keep_next = (in_func == FUNC_SET_LEVEL);
                                cmd_use_next  = (in_func == FUNC_SET_CUSTOM);
                                cmd_mode_next = (in_func == FUNC_SET_LEVEL)
                                              ? in_wstate : MODE_NORMAL;
                                // The other half of the linked pair, if it exists.
                                partner_pend_next = 1'b0;
                                if (is_left && (LINKED_RIGHT < NUM_ICONS)
                                    && (LINKED_RIGHT != LINKED_LEFT))
                                begin
                                    partner_pend_next = 1'b1;
                                    partner_next      = IDX_W'(LINKED_RIGHT);
                                end
                                else if (is_right && (LINKED_LEFT < NUM_ICONS)
                                         && (LINKED_RIGHT != LINKED_LEFT))
                                begin
                                    partner_pend_next = 1'b1;
                                    partner_next      = IDX_W'(LINKED_LEFT);
                                end
                                refresh_next = 1'b1;
                                state_next   = ST_SET_RD;
                            end
                        end
                        FUNC_CLEAR_ALL:
                        begin
                            valid_next   = '0;
                            refresh_next = 1'b1;
                        end
                        FUNC_SET_WORK:
                        begin
                            work_enable_next = in_enable;
                            work_start_next  = in_start;
                            work_end_next    = in_end;
                            work_level_next  = in_level;
                            work_flash_next  = in_flash;
                            if (in_color != '0)
                            begin
                                work_color_next = in_color;
                            end
                            if (in_flash)
                            begin
                                work_toggle_next = in_time;
                                work_phase_next  = 1'b1;
                            end
                            refresh_next = 1'b1;
                        end
                        FUNC_UPDATE:
                        begin
                            addr_next    = '0;
                            toggled_next = 1'b0;
                            state_next   = ST_UPD_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SET_RD:
            begin
                rd_valid_next = valid_reg[addr_reg];
                state_next    = ST_SET_WR;
            end

            ST_SET_WR:
            begin
                ne.mode       = cmd_mode_reg;
                ne.use_custom = cmd_use_reg;
                ne.custom     = cmd_keep_reg ? base.custom : cmd_color_reg;
                ne.flash      = cmd_flash_reg;
                ne.level      = cmd_level_reg;
                if (cmd_flash_reg)
                begin
                    ne.last_toggle = time_reg;
                    ne.phase       = 1'b1;
                end
                mem_we = 1'b1;
                mem_wdata = ENTRY_W'(ne);
                valid_next[addr_reg] = 1'b1;
                // The partner copies the settings just written, custom colour included.
                cmd_color_next = ne.custom;
                cmd_keep_next  = 1'b0;
                if (partner_pend_reg)
                begin
                    partner_pend_next = 1'b0;
                    addr_next         = partner_reg;
                    state_next        = ST_SET_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_UPD_RD:
            begin
                rd_valid_next = valid_reg[addr_reg];
                state_next    = ST_UPD_EV;
            end

            ST_UPD_EV:
            begin
                tog = flashing && (elapsed >= TIME_W'(interval_reg));
                if (tog)
                begin
                    ne.phase       = ~base.phase;
                    ne.last_toggle = time_reg;
                    mem_we         = 1'b1;
                    mem_wdata      = ENTRY_W'(ne);
                    valid_next[addr_reg] = 1'b1;
                    toggled_next   = 1'b1;
                end
                c = base.use_custom ? base.custom : palette(base.mode);
                if (flashing && !ne.phase)
                begin
                    c = '0;
                end
                scale_load  = 1'b1;
                scale_color = c;
                scale_level = base.level;
                state_next  = ST_UPD_OUT;
            end

            ST_UPD_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_first_next   = PIXEL_W'(ICON_PIXEL_BASE) + PIXEL_W'(addr_reg);
                    out_last_px_next = PIXEL_W'(ICON_PIXEL_BASE) + PIXEL_W'(addr_reg);
                    out_color_next   = scaled;
                    out_show_next    = 1'b0;
                    out_end_next     = 1'b0;
                    if (addr_reg == IDX_W'(NUM_ICONS - 1))
                    begin
                        state_next = ST_WORK_EV;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_UPD_RD;
                    end
                end
            end

            ST_WORK_EV:
            begin
                tog = work_flash_reg && work_enable_reg
                    && ((time_reg - work_toggle_reg) >= TIME_W'(interval_reg));
                if (tog)
                begin
                    work_phase_next  = ~work_phase_reg;
                    work_toggle_next = time_reg;
                    toggled_next     = 1'b1;
                end
                if (work_enable_reg && !(work_flash_reg && !(work_phase_reg ^ tog)))
                begin
                    c = work_color_reg;
                end
                scale_load  = 1'b1;
                scale_color = c;
                scale_level = work_level_reg;
                state_next  = ST_WORK_OUT;
            end

            ST_WORK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_first_next   = work_start_reg;
                    out_last_px_next = work_end_reg;
                    out_color_next   = scaled;
                    out_show_next    = toggled_reg || refresh_reg;
                    out_end_next     = 1'b1;
                    refresh_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            refresh_reg      <= 1'b1;
            interval_reg     <= INTERVAL_RESET;
            out_valid_reg    <= 1'b0;
            partner_pend_reg <= 1'b0;
            work_enable_reg  <= 1'b0;
            work_start_reg   <= WORK_START_RESET;
            work_end_reg     <= WORK_END_RESET;
            work_level_reg   <= LEVEL_FULL;
            work_color_reg   <= WORK_COLOR_RESET;
            work_flash_reg   <= 1'b0;
            work_toggle_reg  <= '0;
            work_phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            refresh_reg      <= refresh_next;
            interval_reg     <= interval_next;
            out_valid_reg    <= out_valid_next;
            partner_pend_reg <= partner_pend_next;
            work_enable_reg  <= work_enable_next;
            work_start_reg   <= work_start_next;
            work_end_reg     <= work_end_next;
            work_level_reg   <= work_level_next;
            work_color_reg   <= work_color_next;
            work_flash_reg   <= work_flash_next;
            work_toggle_reg  <= work_toggle_next;
            work_phase_reg   <= work_phase_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        partner_reg     <= partner_next;
        cmd_mode_reg    <= cmd_mode_next;
        cmd_use_reg     <= cmd_use_next;
        cmd_keep_reg    <= cmd_keep_next;
        cmd_color_reg   <= cmd_color_next;
        cmd_flash_reg   <= cmd_flash_next;
        cmd_level_reg   <= cmd_level_next;
        time_reg        <= time_next;
        toggled_reg     <= toggled_next;
        rd_valid_reg    <= rd_valid_next;
        out_first_reg   <= out_first_next;
        out_last_px_reg <= out_last_px_next;
        out_color_reg   <= out_color_next;
        out_show_reg    <= out_show_next;
        out_end_reg     <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_last_px_reg, out_first_reg};
    assign m_tuser  = out_show_reg;
    assign m_tlast  = out_end_reg;

endmodule
